@@ rtl/ups_pkg.sv @@
// Package for the URL path sanitizer: sizes, codes, payload types and
// character helpers. No dependencies.
package ups_pkg;

	localparam int MAX_PATH   = 4096;
	localparam int COMP_DEPTH = MAX_PATH / 2;
	localparam int PW         = $clog2(MAX_PATH);
	localparam int CW         = $clog2(COMP_DEPTH);
	localparam int LW         = PW + 1;
	localparam int INDEX_LEN  = 11;

	typedef logic [1:0] op_t;
	localparam op_t OP_BYTE   = 2'd0;
	localparam op_t OP_FINISH = 2'd1;
	localparam op_t OP_READ   = 2'd2;
	localparam op_t OP_NONE   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_DONE   = 2'd1;
	localparam status_t ST_ESCAPE = 2'd2;
	localparam status_t ST_LONG   = 2'd3;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_STORE = 2'd0;
	localparam mode_t MODE_INDEX = 2'd1;
	localparam mode_t MODE_ROOT  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		op_t        op;
		logic [7:0] path_byte;
		logic [11:0] read_index;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [12:0] out_length;
		logic [7:0]  out_byte;
	} rsp_t;

	typedef struct packed {
		logic       close;
		logic [7:0] ch;
	} emit_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] index_byte(input logic [PW-1:0] i);
		logic [7:0] c;
		case (i)
			PW'(0):  c = CH_SLASH;
			PW'(1):  c = 8'h69;
			PW'(2):  c = 8'h6E;
			PW'(3):  c = 8'h64;
			PW'(4):  c = 8'h65;
			PW'(5):  c = 8'h78;
			PW'(6):  c = CH_DOT;
			PW'(7):  c = 8'h68;
			PW'(8):  c = 8'h74;
			PW'(9):  c = 8'h6D;
			PW'(10): c = 8'h6C;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/ups_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on ups_pkg.
interface ups_req_if;
	logic          valid;
	logic          ready;
	ups_pkg::req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ups_rsp_if;
	logic          valid;
	logic          ready;
	ups_pkg::rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ rtl/ups_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ups_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/url_path_sanitizer_unit.sv @@
// URL path sanitizer top level: percent decoding, dot-segment removal, result readback.
// Depends on ups_pkg, ups_if and ups_ram.
//
// One transaction at a time. A path byte passes through the emit state, which
// handles each decoded byte it releases (at most three) in turn; a byte that
// opens a component also passes through S_PUTB (the '/' and the byte share the
// single path memory write port), and a ".." that pops the component stack
// passes through S_POP (read of the component-start memory); S_OUT then loads
// the response register. A finish takes the same flow for the held escape
// bytes and the final close, plus S_FIN to settle the outcome; a repeated
// finish goes straight to S_OUT. A read within the result passes through S_RD
// (path memory read latency); any other read goes straight to S_OUT. A new
// request is taken while an earlier response still waits on the response channel.
module url_path_sanitizer_unit (
	input logic        clk,
	input logic        arst_n,
	ups_req_if.sink    req,
	ups_rsp_if.source  rsp
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EMIT = 3'd1;
	localparam logic [2:0] S_PUTB = 3'd2;
	localparam logic [2:0] S_POP  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_RD   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam int PW = ups_pkg::PW;
	localparam int CW = ups_pkg::CW;
	localparam int LW = ups_pkg::LW;
	localparam logic [LW-1:0] MAXP  = LW'(ups_pkg::MAX_PATH);
	localparam logic [LW-1:0] DEPTH = LW'(ups_pkg::COMP_DEPTH);

	logic [2:0] state_q;
	logic       accept;

	ups_pkg::emit_t q_q [3];
	logic [1:0]     qn_q, qi_q;
	logic           op_fin_q;

	logic [LW-1:0] raw_len_q;
	logic          raw_end_q;
	logic [7:0]    first_q;
	logic [1:0]    pend_q;
	logic [7:0]    p1_q;

	logic          dec_end_q;
	ups_pkg::status_t err_q;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] wp_q;
	logic [1:0]    cur_len_q;
	logic [LW-1:0] cur_start_q;
	logic [7:0]    b0_q, b1_q;
	logic [7:0]    hold_q;

	logic              fin_q;
	ups_pkg::status_t  fstat_q;
	logic [LW-1:0]     flen_q;
	ups_pkg::mode_t    mode_q;
	logic [PW-1:0]     idx_q;

	ups_pkg::rsp_t res_q;
	logic          rsp_valid_q;
	ups_pkg::rsp_t rsp_q;

	// request decode into an emit list
	ups_pkg::emit_t nq [3];
	logic [1:0]     nn;
	logic [1:0]     np;
	logic [7:0]     np1;
	logic [LW-1:0]  raw_eff;
	logic           raw_end_eff;
	logic [1:0]     pend_eff;
	logic           skipb;
	logic           do_dec;
	logic [7:0]     b;

	// emit-stage memory ports
	logic           pw_en;
	logic [PW-1:0]  pw_addr;
	logic [7:0]     pw_data;
	logic [7:0]     p_rdata;
	logic           cw_en;
	logic [CW-1:0]  c_raddr;
	logic [PW-1:0]  c_rdata;
	logic [LW-1:0]  cnt_m1;

	ups_pkg::emit_t e;
	logic           e_close;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;
	assign b         = req.payload.path_byte;

	always_comb begin
		raw_eff     = fin_q ? '0 : raw_len_q;
		raw_end_eff = fin_q ? 1'b0 : raw_end_q;
		pend_eff    = fin_q ? 2'd0 : pend_q;
		nq[0] = '0;
		nq[1] = '0;
		nq[2] = '0;
		nn    = 2'd0;
		np    = pend_eff;
		np1   = p1_q;
		skipb = 1'b0;
		do_dec = !raw_end_eff && raw_eff < MAXP && b != ups_pkg::CH_NUL &&
			(raw_eff + LW'(1)) < MAXP;
		if (req.payload.op == ups_pkg::OP_FINISH) begin
			if (pend_q != 2'd0) begin
				nq[nn] = '{close: 1'b0, ch: ups_pkg::CH_PCT};
				nn = nn + 2'd1;
			end
			if (pend_q == 2'd2) begin
				nq[nn] = '{close: 1'b0, ch: p1_q};
				nn = nn + 2'd1;
			end
			nq[nn] = '{close: 1'b1, ch: ups_pkg::CH_NUL};
			nn = nn + 2'd1;
			np = 2'd0;
		end else if (do_dec) begin
			if (pend_eff == 2'd2) begin
				np = 2'd0;
				if (ups_pkg::is_hex(b)) begin
					nq[nn] = '{close: 1'b0,
						ch: {ups_pkg::hex_value(p1_q), ups_pkg::hex_value(b)}};
					nn = nn + 2'd1;
					skipb = 1'b1;
				end else begin
					nq[nn] = '{close: 1'b0, ch: ups_pkg::CH_PCT};
					nn = nn + 2'd1;
					nq[nn] = '{close: 1'b0, ch: p1_q};
					nn = nn + 2'd1;
				end
			end else if (pend_eff == 2'd1) begin
				if (ups_pkg::is_hex(b)) begin
					np1 = b;
					np = 2'd2;
					skipb = 1'b1;
				end else begin
					nq[nn] = '{close: 1'b0, ch: ups_pkg::CH_PCT};
					nn = nn + 2'd1;
					np = 2'd0;
				end
			end
			if (!skipb) begin
				if (b == ups_pkg::CH_PCT) begin
					np = 2'd1;
				end else begin
					nq[nn] = '{close: 1'b0,
						ch: (b == ups_pkg::CH_PLUS) ? ups_pkg::CH_SPACE : b};
					nn = nn + 2'd1;
				end
			end
		end
	end

	assign e       = q_q[qi_q];
	assign e_close = e.close ||
		(e.ch == ups_pkg::CH_SLASH && !dec_end_q && err_q == ups_pkg::ST_OK);
	assign cnt_m1  = cnt_q - LW'(1);
	assign c_raddr = cnt_m1[CW-1:0];

	always_comb begin
		pw_en   = 1'b0;
		pw_addr = wp_q[PW-1:0];
		pw_data = hold_q;
		cw_en   = 1'b0;
		if (state_q == S_EMIT && qi_q != qn_q && !e_close && !dec_end_q &&
				err_q == ups_pkg::ST_OK && e.ch != ups_pkg::CH_NUL) begin
			if (cur_len_q == 2'd0) begin
				if (cnt_q < DEPTH) begin
					cw_en   = 1'b1;
					pw_en   = wp_q < MAXP;
					pw_data = ups_pkg::CH_SLASH;
				end
			end else begin
				pw_en   = wp_q < MAXP;
				pw_data = e.ch;
			end
		end else if (state_q == S_PUTB) begin
			pw_en = wp_q < MAXP;
		end
	end

	ups_ram #(.WIDTH(8), .DEPTH(ups_pkg::MAX_PATH)) u_path_ram (
		.clk   (clk),
		.we    (pw_en),
		.waddr (pw_addr),
		.wdata (pw_data),
		.raddr (req.payload.read_index[PW-1:0]),
		.rdata (p_rdata)
	);

	ups_ram #(.WIDTH(PW), .DEPTH(ups_pkg::COMP_DEPTH)) u_comp_ram (
		.clk   (clk),
		.we    (cw_en),
		.waddr (cnt_q[CW-1:0]),
		.wdata (wp_q[PW-1:0]),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qn_q        <= '0;
			qi_q        <= '0;
			op_fin_q    <= 1'b0;
			raw_len_q   <= '0;
			raw_end_q   <= 1'b0;
			first_q     <= '0;
			pend_q      <= '0;
			p1_q        <= '0;
			dec_end_q   <= 1'b0;
			err_q       <= ups_pkg::ST_OK;
			cnt_q       <= '0;
			wp_q        <= '0;
			cur_len_q   <= '0;
			cur_start_q <= '0;
			fin_q       <= 1'b0;
			fstat_q     <= ups_pkg::ST_OK;
			flen_q      <= '0;
			mode_q      <= ups_pkg::MODE_STORE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						q_q   <= nq;
						qn_q  <= nn;
						qi_q  <= '0;
						idx_q <= req.payload.read_index[PW-1:0];
						op_fin_q <= 1'b0;
						state_q  <= S_OUT;
						if (req.payload.op == ups_pkg::OP_BYTE) begin
							if (fin_q) begin
								fin_q     <= 1'b0;
								dec_end_q <= 1'b0;
								err_q     <= ups_pkg::ST_OK;
								cnt_q     <= '0;
								wp_q      <= '0;
								cur_len_q <= '0;
								fstat_q   <= ups_pkg::ST_OK;
								flen_q    <= '0;
								first_q   <= '0;
							end
							raw_len_q <= raw_eff;
							raw_end_q <= raw_end_eff;
							pend_q    <= pend_eff;
							if (!raw_end_eff && raw_eff < MAXP) begin
								if (b == ups_pkg::CH_NUL) begin
									raw_end_q <= 1'b1;
								end else begin
									if (raw_eff == '0) begin
										first_q <= b;
									end
									raw_len_q <= raw_eff + LW'(1);
								end
							end
							if (do_dec) begin
								pend_q <= np;
								p1_q   <= np1;
							end
							state_q <= S_EMIT;
						end else if (req.payload.op == ups_pkg::OP_FINISH) begin
							if (fin_q) begin
								res_q.status     <= fstat_q;
								res_q.out_length <= flen_q;
							end else begin
								pend_q   <= np;
								op_fin_q <= 1'b1;
								state_q  <= S_EMIT;
							end
						end else if (req.payload.op == ups_pkg::OP_READ) begin
							if (fin_q && LW'(req.payload.read_index) < flen_q) begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_EMIT: begin
					if (qi_q == qn_q) begin
						state_q <= op_fin_q ? S_FIN : S_OUT;
					end else begin
						qi_q <= qi_q + 2'd1;
						if (e_close) begin
							cur_len_q <= '0;
							if (err_q == ups_pkg::ST_OK && cur_len_q != 2'd0 &&
									cnt_q < DEPTH) begin
								if (cur_len_q == 2'd1 && b0_q == ups_pkg::CH_DOT) begin
									wp_q <= cur_start_q;
								end else if (cur_len_q == 2'd2 && b0_q == ups_pkg::CH_DOT &&
										b1_q == ups_pkg::CH_DOT) begin
									wp_q <= cur_start_q;
									if (cnt_q == '0) begin
										err_q <= ups_pkg::ST_ESCAPE;
									end else begin
										cnt_q   <= cnt_m1;
										state_q <= S_POP;
									end
								end else begin
									cnt_q <= cnt_q + LW'(1);
								end
							end
						end else if (!dec_end_q && err_q == ups_pkg::ST_OK) begin
							if (e.ch == ups_pkg::CH_NUL) begin
								dec_end_q <= 1'b1;
							end else if (cur_len_q == 2'd0) begin
								if (cnt_q >= DEPTH) begin
									err_q <= ups_pkg::ST_LONG;
								end else begin
									cur_start_q <= wp_q;
									b0_q        <= e.ch;
									hold_q      <= e.ch;
									cur_len_q   <= 2'd1;
									if (wp_q < MAXP) begin
										wp_q <= wp_q + LW'(1);
									end else begin
										err_q <= ups_pkg::ST_LONG;
									end
									state_q <= S_PUTB;
								end
							end else begin
								if (cur_len_q == 2'd1) begin
									b1_q <= e.ch;
								end
								if (cur_len_q != 2'd3) begin
									cur_len_q <= cur_len_q + 2'd1;
								end
								if (wp_q < MAXP) begin
									wp_q <= wp_q + LW'(1);
								end else begin
									err_q <= ups_pkg::ST_LONG;
								end
							end
						end
					end
				end
				S_PUTB: begin
					if (wp_q < MAXP) begin
						wp_q <= wp_q + LW'(1);
					end else if (err_q == ups_pkg::ST_OK) begin
						err_q <= ups_pkg::ST_LONG;
					end
					state_q <= S_EMIT;
				end
				S_POP: begin
					wp_q    <= LW'(c_rdata);
					state_q <= S_EMIT;
				end
				S_FIN: begin
					fin_q   <= 1'b1;
					mode_q  <= ups_pkg::MODE_STORE;
					fstat_q <= ups_pkg::ST_DONE;
					flen_q  <= wp_q;
					res_q.status     <= ups_pkg::ST_DONE;
					res_q.out_length <= wp_q;
					if (raw_len_q >= MAXP) begin
						fstat_q <= ups_pkg::ST_LONG;
						flen_q  <= '0;
						res_q.status     <= ups_pkg::ST_LONG;
						res_q.out_length <= '0;
					end else if (raw_len_q == '0 ||
							(raw_len_q == LW'(1) && first_q == ups_pkg::CH_SLASH)) begin
						mode_q <= ups_pkg::MODE_INDEX;
						flen_q <= LW'(ups_pkg::INDEX_LEN);
						res_q.out_length <= LW'(ups_pkg::INDEX_LEN);
					end else if (err_q != ups_pkg::ST_OK) begin
						fstat_q <= err_q;
						flen_q  <= '0;
						res_q.status     <= err_q;
						res_q.out_length <= '0;
					end else if (cnt_q == '0) begin
						mode_q <= ups_pkg::MODE_ROOT;
						flen_q <= LW'(1);
						res_q.out_length <= LW'(1);
					end else if (wp_q >= MAXP - LW'(1)) begin
						fstat_q <= ups_pkg::ST_LONG;
						flen_q  <= '0;
						res_q.status     <= ups_pkg::ST_LONG;
						res_q.out_length <= '0;
					end
					state_q <= S_OUT;
				end
				S_RD: begin
					case (mode_q)
						ups_pkg::MODE_INDEX: res_q.out_byte <= ups_pkg::index_byte(idx_q);
						ups_pkg::MODE_ROOT:  res_q.out_byte <= ups_pkg::CH_SLASH;
						default:             res_q.out_byte <= p_rdata;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
